// ----- hdl/uart_rx_timeout_packetizer_macros.svh -----
// assertion macros shared by the packetizer rtl
// no dependencies; included by the files that carry assertions
`ifndef UART_RX_TIMEOUT_PACKETIZER_MACROS_SVH
`define UART_RX_TIMEOUT_PACKETIZER_MACROS_SVH
`ifndef SYNTH
`define URTP_ASSERT_HOLD(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define URTP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define URTP_ASSERT_HOLD(name, ante, cons, msg)
`define URTP_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- hdl/urtp_pkg.sv -----
// shared constants, types and helper functions of the uart rx packetizer
// no dependencies
package urtp_pkg;

    localparam int FIFO_DEPTH  = 256;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FILL_W      = PTR_W + 1;
    localparam int TIMER_W     = 17;
    localparam int THRESH_MAX  = 50;
    localparam int MARK_LEN    = 5;
    localparam int LEN_W       = $clog2(THRESH_MAX + MARK_LEN + 1);
    localparam int HDR_LEN     = 9;
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);
    localparam int HDR_CHAN    = 4;
    localparam int MARK_IDX_W  = $clog2(MARK_LEN);
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

    localparam int CHAN_W      = 3;
    localparam int THR_W       = 6;
    localparam int TIMEOUT_W   = 16;
    localparam int STEP_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [31:0] FRAME_TAG = 32'h0000_0034;
    localparam logic [7:0]  LINE_FEED = 8'h0A;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL = 3'd0,
        CFG_THRESH  = 3'd1,
        CFG_TIMEOUT = 3'd2,
        CFG_STEP    = 3'd3,
        CFG_ENDIAN  = 3'd4
    } cfg_idx_t;

    // one request from the front to the back: a drop report or a frame of len bytes
    typedef struct packed {
        logic             drop;
        logic [LEN_W-1:0] len;
    } cmd_t;

    function automatic logic [LEN_W-1:0] clamp_thresh(input logic [THR_W-1:0] s);
        logic [LEN_W-1:0] r;
        if (s == '0)
            r = LEN_W'(1);
        else if (s > THR_W'(THRESH_MAX))
            r = LEN_W'(THRESH_MAX);
        else
            r = LEN_W'(s);
        return r;
    endfunction

    function automatic logic [7:0] marker_byte(input logic [MARK_IDX_W-1:0] idx);
        logic [7:0] r;
        r = (idx == MARK_IDX_W'(2)) ? LINE_FEED : 8'h00;
        return r;
    endfunction

    // tag word, channel byte, length word
    function automatic logic [7:0] header_byte(
        input logic [HDR_IDX_W-1:0] idx,
        input logic [CHAN_W-1:0]    chan,
        input logic [LEN_W-1:0]     len,
        input logic                 big
    );
        logic [31:0] word;
        logic [1:0]  sel;
        logic [7:0]  r;
        if (idx < HDR_IDX_W'(HDR_CHAN))
        begin
            word = FRAME_TAG;
            sel  = idx[1:0];
        end
        else
        begin
            word = 32'(len);
            sel  = 2'(idx - HDR_IDX_W'(HDR_CHAN + 1));
        end
        if (big)
            sel = 2'd3 - sel;
        r = word[{sel, 3'b000} +: 8];
        if (idx == HDR_IDX_W'(HDR_CHAN))
            r = 8'(chan);
        return r;
    endfunction

endpackage

// ----- hdl/urtp_if.sv -----
// valid/ready channel interfaces for received items and emitted results
// no dependencies
interface urtp_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface urtp_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       frame_last;

    modport source (output valid, output out_kind, output out_byte, output frame_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input frame_last,
                    output ready);
endinterface

// ----- hdl/uart_rx_timeout_packetizer.sv -----
// top level of the uart rx idle-timeout packetizer: config registers and wiring
// depends on urtp_pkg, urtp_if, urtp_ram, urtp_front, urtp_cmdq and urtp_back
//
//  port       | dir  | request carries
//  -----------+------+-------------------------------------------
//  item       | in   | opcode (byte / tick), rx_byte
//  result     | out  | out_kind (frame / drop), out_byte, frame_last
//  cfg_*      | in   | write enable, register index, write data
//
// an item is taken while idle and handled in the next cycle; no new item is taken until it is done
// a byte waits while the ram is full of entries a frame has not yet read, or while its drop request is not taken
// a timeout flush writes five marker bytes (one ram write port), then issues one request
// a frame leaves at one byte per cycle while the result side is ready: nine header bytes, then length data bytes
// result back-pressure fills the four-entry request queue, then stops input
// reset clears pointers, counters, timer and config; ram contents are not cleared
module uart_rx_timeout_packetizer (
    input  logic                             clk,
    input  logic                             rst_n,
    urtp_in_if.sink                          item,
    urtp_out_if.source                       result,
    input  logic                             cfg_we,
    input  logic [urtp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [urtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import urtp_pkg::*;

    logic [CHAN_W-1:0]    channel_id_reg;
    logic [THR_W-1:0]     send_threshold_reg;
    logic [TIMEOUT_W-1:0] timeout_limit_reg;
    logic [STEP_W-1:0]    time_step_reg;
    logic                 big_endian_reg;

    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [PTR_W-1:0]     rd_addr;
    logic [7:0]           rd_data;
    logic                 push_valid;
    logic                 push_ready;
    cmd_t                 push_cmd;
    logic                 pop_valid;
    logic                 pop_ready;
    cmd_t                 pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_id_reg     <= CHAN_W'(1);
            send_threshold_reg <= THR_W'(32);
            timeout_limit_reg  <= TIMEOUT_W'(100);
            time_step_reg      <= STEP_W'(10);
            big_endian_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CHANNEL: channel_id_reg     <= cfg_data[CHAN_W-1:0];
                CFG_THRESH:  send_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_TIMEOUT: timeout_limit_reg  <= cfg_data[TIMEOUT_W-1:0];
                CFG_STEP:    time_step_reg      <= cfg_data[STEP_W-1:0];
                CFG_ENDIAN:  big_endian_reg     <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    urtp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .send_threshold (send_threshold_reg),
        .timeout_limit  (timeout_limit_reg),
        .time_step      (time_step_reg),
        .pop            (rd_en),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .cmd_valid      (push_valid),
        .cmd            (push_cmd),
        .cmd_ready      (push_ready)
    );

    urtp_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    urtp_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    urtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd        (pop_cmd),
        .cmd_ready  (pop_ready),
        .channel_id (channel_id_reg),
        .big_endian (big_endian_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .result     (result)
    );

endmodule

// ----- hdl/urtp_ram.sv -----
// simple dual-port byte store, one write and one registered read per cycle
// no dependencies
module urtp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/urtp_front.sv -----
// front end: takes items, keeps the fifo write pointer, fill and idle timer, issues requests
// depends on urtp_pkg, urtp_if and the assertion macros
`include "uart_rx_timeout_packetizer_macros.svh"
module urtp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    urtp_in_if.sink                          item,
    input  logic [urtp_pkg::THR_W-1:0]       send_threshold,
    input  logic [urtp_pkg::TIMEOUT_W-1:0]   timeout_limit,
    input  logic [urtp_pkg::STEP_W-1:0]      time_step,
    input  logic                             pop,
    output logic                             wr_en,
    output logic [urtp_pkg::PTR_W-1:0]       wr_addr,
    output logic [7:0]                       wr_data,
    output logic                             cmd_valid,
    output urtp_pkg::cmd_t                   cmd,
    input  logic                             cmd_ready
);
    import urtp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_MARK,
        S_CLOSE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    op_reg, op_next;
    logic [7:0]              byte_reg, byte_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    // entries still held in ram, including bytes already handed to the back
    logic [FILL_W-1:0]       phys_reg, phys_next;
    logic [TIMER_W-1:0]      timer_reg, timer_next;
    logic [MARK_IDX_W-1:0]   mark_idx_reg, mark_idx_next;

    logic [LEN_W-1:0]        thr;
    logic                    fill_over;
    logic                    timed_out;
    logic                    fifo_full;
    logic                    phys_room;
    logic                    mark_room;

    assign thr       = clamp_thresh(send_threshold);
    assign fill_over = fill_reg > FILL_W'(thr);
    assign timed_out = timer_reg > TIMER_W'(timeout_limit);
    assign fifo_full = fill_reg == FILL_W'(FIFO_DEPTH);
    assign phys_room = phys_reg < FILL_W'(FIFO_DEPTH);
    assign mark_room = phys_reg <= FILL_W'(FIFO_DEPTH - MARK_LEN);

    assign item.ready = state_reg == S_IDLE;
    assign wr_addr    = wr_ptr_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        byte_next     = byte_reg;
        fill_next     = fill_reg;
        timer_next    = timer_reg;
        mark_idx_next = mark_idx_reg;
        wr_en         = 1'b0;
        wr_data       = byte_reg;
        cmd_valid     = 1'b0;
        cmd           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next    = item.opcode;
                    byte_next  = item.rx_byte;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == OP_BYTE)
                begin
                    timer_next = '0;
                    if (fifo_full)
                    begin
                        cmd_valid = 1'b1;
                        cmd.drop  = 1'b1;
                        if (cmd_ready)
                            state_next = S_IDLE;
                    end
                    else if (phys_room)
                    begin
                        wr_en      = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (fill_over)
                begin
                    cmd_valid = 1'b1;
                    cmd.len   = thr;
                    if (cmd_ready)
                    begin
                        fill_next  = fill_reg - FILL_W'(thr);
                        state_next = S_IDLE;
                    end
                end
                else if (timed_out)
                begin
                    if (fill_reg == '0)
                        state_next = S_IDLE;
                    else if (mark_room)
                    begin
                        mark_idx_next = '0;
                        state_next    = S_MARK;
                    end
                end
                else
                begin
                    timer_next = timer_reg + TIMER_W'(time_step);
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                wr_en         = 1'b1;
                wr_data       = marker_byte(mark_idx_reg);
                fill_next     = fill_reg + 1'b1;
                mark_idx_next = mark_idx_reg + 1'b1;
                if (mark_idx_reg == MARK_IDX_W'(MARK_LEN - 1))
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                cmd_valid = 1'b1;
                cmd.len   = fill_reg[LEN_W-1:0];
                if (cmd_ready)
                begin
                    fill_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign phys_next   = phys_reg + FILL_W'(wr_en) - FILL_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_BYTE;
            byte_reg     <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            phys_reg     <= '0;
            timer_reg    <= '0;
            mark_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            byte_reg     <= byte_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            phys_reg     <= phys_next;
            timer_reg    <= timer_next;
            mark_idx_reg <= mark_idx_next;
        end
    end

    `URTP_ASSERT_HOLD(a_phys_covers_fill, 1'b1, phys_reg >= fill_reg, "ram count below fill")
    `URTP_ASSERT_HOLD(a_write_has_room, wr_en, phys_reg < FILL_W'(FIFO_DEPTH), "write into full ram")
    `URTP_ASSERT_HOLD(a_frame_not_empty, cmd_valid && !cmd.drop, cmd.len != '0, "empty frame request")

endmodule

// ----- hdl/urtp_cmdq.sv -----
// short request queue between the front and the back
// depends on urtp_pkg
module urtp_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  urtp_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output urtp_pkg::cmd_t  pop_data
);
    import urtp_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] head_reg, head_next;
    logic [CMDQ_PTR_W-1:0] tail_reg, tail_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (CMDQ_PTR_W + 1)'(CMDQ_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[head_reg];

    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign head_next  = do_pop ? head_reg + 1'b1 : head_reg;
    assign tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
    assign count_next = count_reg + (CMDQ_PTR_W + 1)'(do_push) - (CMDQ_PTR_W + 1)'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[tail_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/urtp_back.sv -----
// back end: turns requests into drop reports or framed byte streams, output register
// depends on urtp_pkg, urtp_if and the assertion macros
`include "uart_rx_timeout_packetizer_macros.svh"
module urtp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  urtp_pkg::cmd_t                cmd,
    output logic                          cmd_ready,
    input  logic [urtp_pkg::CHAN_W-1:0]   channel_id,
    input  logic                          big_endian,
    output logic                          rd_en,
    output logic [urtp_pkg::PTR_W-1:0]    rd_addr,
    input  logic [7:0]                    rd_data,
    urtp_out_if.source                    result
);
    import urtp_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DROP,
        B_HDR,
        B_DATA
    } state_t;

    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic [LEN_W-1:0]       out_cnt_reg, out_cnt_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    // ram read data is pending in the read register
    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic                   s1_move;

    assign out_free  = !out_valid_reg || result.ready;
    assign s1_move   = state_reg == B_DATA && s1_valid_reg && out_free;
    assign rd_en     = (state_reg == B_HDR || state_reg == B_DATA) && issue_cnt_reg != '0
                       && (!s1_valid_reg || s1_move);
    assign rd_addr   = rd_ptr_reg;
    assign cmd_ready = state_reg == B_IDLE;

    assign result.valid      = out_valid_reg;
    assign result.out_kind   = out_kind_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.frame_last = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        issue_cnt_next = issue_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        hdr_idx_next   = hdr_idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.drop)
                        state_next = B_DROP;
                    else
                    begin
                        len_next       = cmd.len;
                        issue_cnt_next = cmd.len;
                        out_cnt_next   = cmd.len;
                        hdr_idx_next   = '0;
                        state_next     = B_HDR;
                    end
                end
            end
            B_DROP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DROP;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            B_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_byte_next  = header_byte(hdr_idx_reg, channel_id, len_reg, big_endian);
                    out_last_next  = 1'b0;
                    hdr_idx_next   = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == HDR_IDX_W'(HDR_LEN - 1))
                        state_next = B_DATA;
                end
            end
            B_DATA:
            begin
                if (s1_move)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_byte_next  = rd_data;
                    out_last_next  = out_cnt_reg == LEN_W'(1);
                    out_cnt_next   = out_cnt_reg - 1'b1;
                    if (out_cnt_reg == LEN_W'(1))
                        state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (rd_en)
            issue_cnt_next = issue_cnt_next - 1'b1;
    end

    assign rd_ptr_next   = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign s1_valid_next = rd_en ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            len_reg       <= '0;
            issue_cnt_reg <= '0;
            out_cnt_reg   <= '0;
            hdr_idx_reg   <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_FRAME;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            issue_cnt_reg <= issue_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            hdr_idx_reg   <= hdr_idx_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    `URTP_ASSERT_HOLD(a_data_balance, state_reg == B_HDR || state_reg == B_DATA, out_cnt_reg == issue_cnt_reg + LEN_W'(s1_valid_reg), "data count mismatch")
    `URTP_ASSERT_HOLD(a_read_in_frame, s1_valid_reg, state_reg == B_HDR || state_reg == B_DATA, "read data outside a frame")
    `URTP_ASSERT_NEXT(a_last_ends_frame, s1_move && out_cnt_reg == LEN_W'(1), state_reg == B_IDLE && !s1_valid_reg && issue_cnt_reg == '0, "frame not closed after last byte")

endmodule

// ----- dv/uart_rx_timeout_packetizer_tb.sv -----
// testbench of the uart rx idle-timeout packetizer: directed and random requests,
// every result checked against an in-bench model of the fifo, idle timer and framing
// depends on urtp_pkg, urtp_if and the uart_rx_timeout_packetizer rtl
module uart_rx_timeout_packetizer_tb;
    import urtp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } frame_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    urtp_in_if  item_ch ();
    urtp_out_if result_ch ();

    uart_rx_timeout_packetizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model copy of the registers and state
    logic [CHAN_W-1:0]    chan_reg;
    logic [THR_W-1:0]     thresh_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 big_reg;
    logic [7:0]           ring [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr;
    logic [PTR_W-1:0]     rd_ptr;
    int                   fill_level;
    logic [TIMER_W-1:0]   idle_time;

    frame_out_t pending_bytes [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    bit hold_active   = 1'b0;

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int frames_built = 0;
    int drops_built  = 0;
    int cycle_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void queue_byte(logic kind, logic [7:0] data, logic last);
        pending_bytes.push_back(frame_out_t'{kind, data, last});
    endfunction

    function automatic void queue_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            queue_byte(KIND_FRAME, big_reg ? w[8*(3-i) +: 8] : w[8*i +: 8], 1'b0);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr++;
        fill_level++;
    endfunction

    function automatic void queue_frame(int len);
        queue_word(FRAME_TAG);
        queue_byte(KIND_FRAME, 8'(chan_reg), 1'b0);
        queue_word(32'(len));
        for (int i = 0; i < len; i++)
        begin
            queue_byte(KIND_FRAME, ring[rd_ptr], i == len - 1);
            rd_ptr++;
            fill_level--;
        end
        frames_built++;
    endfunction

    function automatic void predict_item(logic op, logic [7:0] b);
        int frame_len;
        if (thresh_reg == '0)
            frame_len = 1;
        else if (thresh_reg > THRESH_MAX)
            frame_len = THRESH_MAX;
        else
            frame_len = int'(thresh_reg);

        if (op == OP_BYTE)
        begin
            idle_time = '0;
            if (fill_level >= FIFO_DEPTH)
            begin
                queue_byte(KIND_DROP, 8'h00, 1'b1);
                drops_built++;
            end
            else
                store_byte(b);
        end
        else if (fill_level > frame_len)
            queue_frame(frame_len);
        else if (idle_time > timeout_reg)
        begin
            // timer stays where it is, with or without a flush
            if (fill_level > 0)
            begin
                for (int k = 0; k < MARK_LEN; k++)
                    store_byte(k == 2 ? LINE_FEED : 8'h00);
                queue_frame(fill_level);
            end
        end
        else
            idle_time = idle_time + TIMER_W'(step_reg);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predict_item(op, b);
        items_sent++;
    endtask

    task automatic stop_items();
        item_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        stop_items();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // bytes and quiet ticks leave nothing to wait for, so give them time to settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic configure(logic [CHAN_W-1:0] chan, logic [THR_W-1:0] thr,
                             logic [TIMEOUT_W-1:0] tmo, logic [STEP_W-1:0] step_val,
                             logic big);
        wait_idle();
        write_reg(CFG_CHANNEL, CFG_DATA_W'(chan));
        write_reg(CFG_THRESH,  CFG_DATA_W'(thr));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(CFG_STEP,    CFG_DATA_W'(step_val));
        write_reg(CFG_ENDIAN,  CFG_DATA_W'(big));
        cfg_we <= 1'b0;
        @(posedge clk);
        chan_reg    = chan;
        thresh_reg  = thr;
        timeout_reg = tmo;
        step_reg    = step_val;
        big_reg     = big;
    endtask

    task automatic tick_until_empty();
        while (fill_level > 0)
            send_item(OP_TICK, 8'($urandom));
    endtask

    // ---------------------------------------------------------------- receiver

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            else if (hold_left > 0)
                hold_left--;
            hold_active = hold_left > 0;
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= !hold_active && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
        end
    endfunction

    initial
    begin
        frame_out_t got;
        frame_out_t want;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got = frame_out_t'{result_ch.out_kind, result_ch.out_byte,
                                   result_ch.frame_last};
                results_seen++;
                if (pending_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s %0d byte %02h last %0d",
                             $time, "actual kind", got.kind, got.data, got.last);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    check_field("out_kind", 8'(want.kind), 8'(got.kind));
                    check_field("out_byte", want.data, got.data);
                    check_field("frame_last", 8'(want.last), 8'(got.last));
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset values: threshold 32, timeout 100, step 10, little endian, channel 1
    task automatic test_reset_defaults();
        send_item(OP_BYTE, 8'h41);
        send_item(OP_BYTE, 8'h42);
        send_item(OP_BYTE, 8'h43);
        tick_until_empty();
    endtask

    task automatic test_directed_edges();
        // threshold zero acts as one, channel zero, zero step freezes the timer
        configure(3'd0, 6'd0, 16'd0, 10'd0, 1'b1);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, 8'h5A);
        repeat (4) send_item(OP_TICK, 8'hFF);

        // timeout flush with marker, then ticks with an empty fifo and an expired timer
        configure(3'd7, 6'd51, 16'd0, 10'd1, 1'b0);
        send_item(OP_BYTE, 8'h0A);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'h00);

        // fill equal to the threshold sends nothing, one more byte sends a fixed frame
        configure(3'd3, 6'd3, 16'hFFFF, 10'd1, 1'b1);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, 8'h7F);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'hFE);
        send_item(OP_TICK, 8'h00);
    endtask

    // largest timeout, largest step and a threshold above the saturation point
    task automatic test_long_timeout();
        configure(3'd7, 6'd63, 16'hFFFF, 10'h3FF, 1'b1);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_BYTE, 8'hAA);
        tick_until_empty();
    endtask

    task automatic test_fifo_overflow();
        send_idle_pct = 12;
        stall_pct     = 12;
        configure(3'd2, 6'd50, 16'd0, 10'd5, 1'b0);
        repeat (FIFO_DEPTH + 2) send_item(OP_BYTE, 8'($urandom));
        tick_until_empty();
    endtask

    task automatic test_random_traffic();
        int phase_items;
        int burst;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            configure(CHAN_W'($urandom), THR_W'($urandom),
                      ($urandom_range(0, 3) == 0) ? TIMEOUT_W'($urandom)
                                                  : TIMEOUT_W'($urandom_range(0, 200)),
                      ($urandom_range(0, 3) == 0) ? STEP_W'($urandom)
                                                  : STEP_W'($urandom_range(1, 60)),
                      1'($urandom));
            phase_items = 0;
            while (phase_items < 15)
            begin
                // a burst of received bytes followed by a few ticks
                burst = $urandom_range(0, 12);
                repeat (burst) send_item(OP_BYTE, 8'($urandom));
                phase_items += burst;
                burst = $urandom_range(1, 4);
                repeat (burst) send_item(OP_TICK, 8'($urandom));
                phase_items += burst;
            end
        end
    endtask

    // receiver holds off while frames keep being requested, so the input must stall
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(3'd5, 6'd1, 16'd1000, 10'd1, 1'b0);
        hold_request = HOLD_CYCLES;
        repeat (10)
        begin
            send_item(OP_BYTE, 8'($urandom));
            send_item(OP_BYTE, 8'($urandom));
            send_item(OP_TICK, 8'($urandom));
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_CHANNEL;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_BYTE;
        item_ch.rx_byte = '0;

        chan_reg    = CHAN_W'(1);
        thresh_reg  = THR_W'(32);
        timeout_reg = TIMEOUT_W'(100);
        step_reg    = STEP_W'(10);
        big_reg     = 1'b0;
        wr_ptr      = '0;
        rd_ptr      = '0;
        fill_level  = 0;
        idle_time   = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_edges();
        test_long_timeout();
        test_fifo_overflow();
        test_random_traffic();
        test_output_backpressure();

        stop_items();
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in, %0d results out, %0d frames and %0d drop reports predicted",
                 items_sent, results_seen, frames_built, drops_built);
        $display("register extremes, fifo overflow, timeouts and four idle mixes with a long hold-off");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
